// ===== hdl/hrbp_pkg.sv =====
// Package for the HTTP request byte parser: parse phases, status and role codes,
// character class helpers. No dependencies.
`default_nettype none
package hrbp_pkg;

   localparam int LengthBitsDefault = 32;
   localparam int ClLen = 14;
   localparam logic [4:0] MatchFail = 5'd31;

   typedef enum logic [22:0] {
      PH_METHOD0 = 23'd1 << 0,
      PH_METHOD  = 23'd1 << 1,
      PH_URL0    = 23'd1 << 2,
      PH_URL     = 23'd1 << 3,
      PH_H       = 23'd1 << 4,
      PH_T1      = 23'd1 << 5,
      PH_T2      = 23'd1 << 6,
      PH_P       = 23'd1 << 7,
      PH_SLASH   = 23'd1 << 8,
      PH_MAJ0    = 23'd1 << 9,
      PH_MAJ     = 23'd1 << 10,
      PH_MIN0    = 23'd1 << 11,
      PH_MIN     = 23'd1 << 12,
      PH_LF1     = 23'd1 << 13,
      PH_LINE    = 23'd1 << 14,
      PH_CONT    = 23'd1 << 15,
      PH_NAME    = 23'd1 << 16,
      PH_SP      = 23'd1 << 17,
      PH_VALUE   = 23'd1 << 18,
      PH_LF2     = 23'd1 << 19,
      PH_ENDLF   = 23'd1 << 20,
      PH_BODY    = 23'd1 << 21,
      PH_DONE    = 23'd1 << 22
   } phase_type;

   typedef enum logic [1:0] {
      ST_MORE = 2'd0, ST_GOOD = 2'd1, ST_BAD = 2'd2, ST_IGN = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      R_METHOD = 3'd0, R_PATH = 3'd1, R_QUERY = 3'd2, R_NAME = 3'd3,
      R_VALUE = 3'd4, R_CONTENT = 3'd5, R_FRAME = 3'd6, R_NONE = 3'd7
   } role_type;

   function automatic logic is_ctl(input logic [7:0] c);
      return (c <= 8'd31) || (c == 8'd127);
   endfunction

   function automatic logic is_tspec(input logic [7:0] c);
      logic r;
      case (c)
         "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]",
         "?", "=", "{", "}", " ", 8'h09: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic is_token(input logic [7:0] c);
      return !c[7] && !is_ctl(c) && !is_tspec(c);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_text(input logic [7:0] c);
      return (c >= 8'd32) && (c <= 8'd126);
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
   endfunction

   // Lower-case "content-length", one character per position
   function automatic logic [7:0] cl_char(input logic [3:0] pos);
      logic [7:0] r;
      case (pos)
         4'd0: r = "c";  4'd1: r = "o";  4'd2: r = "n";  4'd3: r = "t";
         4'd4: r = "e";  4'd5: r = "n";  4'd6: r = "t";  4'd7: r = "-";
         4'd8: r = "l";  4'd9: r = "e";  4'd10: r = "n"; 4'd11: r = "g";
         4'd12: r = "t"; 4'd13: r = "h";
         default: r = 8'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/http_request_byte_parser_core.sv =====
// HTTP/1.x request byte parser, top level.
// Depends on hrbp_pkg for phase, status and role codes and character classes.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | req_restart, req_byte_req
//  rsp     | out       | rsp_valid/rsp_stall | rsp_status, rsp_byte_role,
//          |           |                     | rsp_header_start, rsp_body_length
//
// One request byte per cycle unless stalled; each result shows the next cycle.
// Parse state updates in the accept cycle; the result register holds the result.
// A request is taken while the result register is empty or being drained.
// Reset (synchronous, active high) returns the parser to the start of a method.
// The length check uses a wide add and compare, which sets the clock period.
`default_nettype none
module http_request_byte_parser_core #(
   parameter int LENGTH_BITS = hrbp_pkg::LengthBitsDefault
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire         req_restart,
   input  wire  [7:0]  req_byte_req,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_byte_role,
   output logic        rsp_header_start,
   output logic [31:0] rsp_body_length
);

   localparam logic [LENGTH_BITS-1:0] LenMax = '1;
   localparam int AccBits = LENGTH_BITS + 4;

   hrbp_pkg::phase_type phase_ff, phase_in;
   logic question_seen_ff, question_seen_in;
   logic any_header_ff, any_header_in;
   logic [4:0] match_pos_ff, match_pos_in;
   logic name_is_length_ff, name_is_length_in;
   logic [1:0] lp_phase_ff, lp_phase_in;
   logic [LENGTH_BITS-1:0] accum_ff, accum_in;
   logic [LENGTH_BITS-1:0] target_ff, target_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   logic neg_ff, neg_in, digit_ff, digit_in, ovf_ff, ovf_in, lbad_ff, lbad_in;

   logic        rsp_valid_ff;
   logic [1:0]  status_ff, status_in;
   logic [2:0]  role_ff, role_in;
   logic        hs_ff, hs_in;
   logic [31:0] blen_ff, blen_in;

   logic accept;
   logic [7:0] c;
   logic [AccBits-1:0] acc_times10;
   logic [LENGTH_BITS-1:0] count_inc;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign c         = req_byte_req;
   assign acc_times10 = AccBits'(accum_ff) * AccBits'(10) + AccBits'(c[3:0]);
   assign count_inc = count_ff + LENGTH_BITS'(1);

   // Work out next parse state and result for the incoming byte
   always_comb begin
      hrbp_pkg::phase_type ph;
      logic qs, ah, nil, bad, lclose;
      logic [4:0] mp;
      logic [1:0] lp;
      logic [LENGTH_BITS-1:0] acc, tgt, cnt;
      logic ng, dg, ov, lb;
      logic [1:0] st;
      logic [2:0] role;
      logic hs;

      ph = phase_ff; qs = question_seen_ff; ah = any_header_ff; mp = match_pos_ff;
      nil = name_is_length_ff; lp = lp_phase_ff; acc = accum_ff; tgt = target_ff;
      cnt = count_ff; ng = neg_ff; dg = digit_ff; ov = ovf_ff; lb = lbad_ff;
      if (req_restart) begin
         ph = hrbp_pkg::PH_METHOD0; qs = 1'b0; ah = 1'b0; mp = '0; nil = 1'b0;
         lp = '0; acc = '0; tgt = '0; cnt = '0; ng = 1'b0; dg = 1'b0; ov = 1'b0;
         lb = 1'b0;
      end
      st = hrbp_pkg::ST_MORE; role = hrbp_pkg::R_FRAME; hs = 1'b0; bad = 1'b0;
      lclose = 1'b0;

      unique case (ph)
         hrbp_pkg::PH_METHOD0, hrbp_pkg::PH_METHOD: begin
            if (hrbp_pkg::is_token(c)) begin
               role = hrbp_pkg::R_METHOD; ph = hrbp_pkg::PH_METHOD;
            end else if (ph == hrbp_pkg::PH_METHOD && c == " ") ph = hrbp_pkg::PH_URL0;
            else bad = 1'b1;
         end
         hrbp_pkg::PH_URL0, hrbp_pkg::PH_URL: begin
            if (!hrbp_pkg::is_ctl(c) && c != " ") begin
               if (qs) role = hrbp_pkg::R_QUERY;
               else if (c == "?") qs = 1'b1;
               else role = hrbp_pkg::R_PATH;
               ph = hrbp_pkg::PH_URL;
            end else if (ph == hrbp_pkg::PH_URL && c == " ") ph = hrbp_pkg::PH_H;
            else bad = 1'b1;
         end
         hrbp_pkg::PH_H:  if (c == "H") ph = hrbp_pkg::PH_T1; else bad = 1'b1;
         hrbp_pkg::PH_T1: if (c == "T") ph = hrbp_pkg::PH_T2; else bad = 1'b1;
         hrbp_pkg::PH_T2: if (c == "T") ph = hrbp_pkg::PH_P; else bad = 1'b1;
         hrbp_pkg::PH_P:  if (c == "P") ph = hrbp_pkg::PH_SLASH; else bad = 1'b1;
         hrbp_pkg::PH_SLASH: if (c == "/") ph = hrbp_pkg::PH_MAJ0; else bad = 1'b1;
         hrbp_pkg::PH_MAJ0: if (hrbp_pkg::is_digit(c)) ph = hrbp_pkg::PH_MAJ;
                            else bad = 1'b1;
         hrbp_pkg::PH_MAJ: begin
            if (c == ".") ph = hrbp_pkg::PH_MIN0;
            else if (!hrbp_pkg::is_digit(c)) bad = 1'b1;
         end
         hrbp_pkg::PH_MIN0: if (hrbp_pkg::is_digit(c)) ph = hrbp_pkg::PH_MIN;
                            else bad = 1'b1;
         hrbp_pkg::PH_MIN: begin
            if (c == 8'h0d) ph = hrbp_pkg::PH_LF1;
            else if (!hrbp_pkg::is_digit(c)) bad = 1'b1;
         end
         hrbp_pkg::PH_LF1, hrbp_pkg::PH_LF2: begin
            if (c == 8'h0a) ph = hrbp_pkg::PH_LINE; else bad = 1'b1;
         end
         hrbp_pkg::PH_LINE: begin
            if (c == " " || c == 8'h09) begin
               if (ah) ph = hrbp_pkg::PH_CONT; else bad = 1'b1;
            end else if (hrbp_pkg::is_token(c)) begin
               lclose = 1'b1;
               ah = 1'b1;
               mp = (hrbp_pkg::to_lower(c) == hrbp_pkg::cl_char(4'd0)) ? 5'd1
                                                                       : hrbp_pkg::MatchFail;
               role = hrbp_pkg::R_NAME; hs = 1'b1; ph = hrbp_pkg::PH_NAME;
            end else if (c == 8'h0d) ph = hrbp_pkg::PH_ENDLF;
            else bad = 1'b1;
         end
         hrbp_pkg::PH_CONT, hrbp_pkg::PH_VALUE: begin
            if (ph == hrbp_pkg::PH_CONT && (c == " " || c == 8'h09)) begin
               // drop continuation blanks
            end else if (c == 8'h0d) ph = hrbp_pkg::PH_LF2;
            else if (hrbp_pkg::is_text(c)) begin
               role = hrbp_pkg::R_VALUE;
               ph = hrbp_pkg::PH_VALUE;
               if (nil) begin
                  if (lp == 2'd0 && c == " ") begin
                     // skip leading spaces
                  end else if (lp == 2'd0 && (c == "+" || c == "-")) begin
                     ng = (c == "-"); lp = 2'd1;
                  end else if (lp != 2'd3 && hrbp_pkg::is_digit(c)) begin
                     dg = 1'b1; lp = 2'd2;
                     if (!ov) begin
                        if (acc_times10 > AccBits'(LenMax)) ov = 1'b1;
                        else acc = acc_times10[LENGTH_BITS-1:0];
                     end
                  end else lp = 2'd3;
               end
            end else bad = 1'b1;
         end
         hrbp_pkg::PH_NAME: begin
            if (hrbp_pkg::is_token(c)) begin
               if (mp < 5'(hrbp_pkg::ClLen) &&
                   hrbp_pkg::to_lower(c) == hrbp_pkg::cl_char(mp[3:0]))
                  mp = mp + 5'd1;
               else mp = hrbp_pkg::MatchFail;
               role = hrbp_pkg::R_NAME;
            end else if (c == ":") begin
               nil = (mp == 5'(hrbp_pkg::ClLen));
               lp = '0; acc = '0; ng = 1'b0; dg = 1'b0; ov = 1'b0;
               ph = hrbp_pkg::PH_SP;
            end else bad = 1'b1;
         end
         hrbp_pkg::PH_SP: if (c == " ") ph = hrbp_pkg::PH_VALUE; else bad = 1'b1;
         hrbp_pkg::PH_ENDLF: begin
            if (c != 8'h0a) bad = 1'b1;
            else lclose = 1'b1;
         end
         hrbp_pkg::PH_BODY: begin
            role = hrbp_pkg::R_CONTENT;
            cnt = count_inc;
            if (count_inc >= tgt) begin
               st = hrbp_pkg::ST_GOOD; ph = hrbp_pkg::PH_DONE;
            end
         end
         default: begin
            st = hrbp_pkg::ST_IGN; role = hrbp_pkg::R_NONE; ph = hrbp_pkg::PH_DONE;
         end
      endcase

      // Close an open Content-Length value
      if (lclose && nil) begin
         if (!dg || ov || (ng && acc != '0)) lb = 1'b1;
         else tgt = acc;
         nil = 1'b0;
      end
      if (ph == hrbp_pkg::PH_ENDLF && lclose) begin
         if (lb) bad = 1'b1;
         else if (tgt == '0) begin
            st = hrbp_pkg::ST_GOOD; ph = hrbp_pkg::PH_DONE;
         end else begin
            cnt = '0; ph = hrbp_pkg::PH_BODY;
         end
      end

      if (bad) begin
         st = hrbp_pkg::ST_BAD; role = hrbp_pkg::R_NONE; hs = 1'b0;
         ph = hrbp_pkg::PH_DONE;
      end

      phase_in = ph; question_seen_in = qs; any_header_in = ah; match_pos_in = mp;
      name_is_length_in = nil; lp_phase_in = lp; accum_in = acc; target_in = tgt;
      count_in = cnt; neg_in = ng; digit_in = dg; ovf_in = ov; lbad_in = lb;
      status_in = st; role_in = role; hs_in = hs;
      blen_in = (st == hrbp_pkg::ST_GOOD) ? 32'(64'(tgt)) : 32'd0;
   end

   // Advance parse state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hrbp_pkg::PH_METHOD0;
         question_seen_ff <= 1'b0; any_header_ff <= 1'b0; match_pos_ff <= '0;
         name_is_length_ff <= 1'b0; lp_phase_ff <= '0; accum_ff <= '0;
         target_ff <= '0; count_ff <= '0; neg_ff <= 1'b0; digit_ff <= 1'b0;
         ovf_ff <= 1'b0; lbad_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         question_seen_ff <= question_seen_in; any_header_ff <= any_header_in;
         match_pos_ff <= match_pos_in; name_is_length_ff <= name_is_length_in;
         lp_phase_ff <= lp_phase_in; accum_ff <= accum_in; target_ff <= target_in;
         count_ff <= count_in; neg_ff <= neg_in; digit_ff <= digit_in;
         ovf_ff <= ovf_in; lbad_ff <= lbad_in;
      end
   end

   // Hold the result until it is taken
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (accept) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in; role_ff <= role_in; hs_ff <= hs_in; blen_ff <= blen_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_byte_role    = role_ff;
   assign rsp_header_start = hs_ff;
   assign rsp_body_length  = blen_ff;

   a_one_hot: assert property (@(posedge clock) disable iff (reset) $onehot(phase_ff))
      else $error("parse phase not one-hot");
   a_bad_role: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == hrbp_pkg::ST_BAD || rsp_status == hrbp_pkg::ST_IGN)
      |-> rsp_byte_role == hrbp_pkg::R_NONE && !rsp_header_start)
      else $error("bad or ignored byte carries a role");
   a_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != hrbp_pkg::ST_GOOD |-> rsp_body_length == 32'd0)
      else $error("length shown without good status");
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      accept && !req_restart && phase_ff == hrbp_pkg::PH_DONE
      |=> rsp_status == hrbp_pkg::ST_IGN)
      else $error("byte after finish not ignored");
   a_body_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == hrbp_pkg::PH_BODY |-> count_ff < target_ff)
      else $error("body count passed its target");

endmodule
`default_nettype wire
